// ===== src/hbne_pkg.sv =====
// ---------------------------------------------------------------------------
// hbne_pkg
// Shared types, constants and helpers for the Hamming-ball enumerator.
// ---------------------------------------------------------------------------
package hbne_pkg;

  localparam int SLICE_BITS = 8;   // 2..10
  localparam int MAX_RADIUS = 2;   // 0..2
  localparam int FIELD_W    = 8;   // width of slice_value / neighbour_value
  localparam int POS_W      = $clog2(SLICE_BITS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [1:0] DIST0 = 2'd0;
  localparam logic [1:0] DIST1 = 2'd1;
  localparam logic [1:0] DIST2 = 2'd2;

  localparam logic [1:0] RADIUS_RST = 2'd1;
  localparam logic [1:0] RADIUS_MAX = 2'(MAX_RADIUS);

  typedef logic [SLICE_BITS-1:0] slice_t;

  // one queued job: masked slice and saturated radius
  typedef struct packed {
    slice_t     val;
    logic [1:0] rad;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // field -> slice width (truncate or zero-extend)
  function automatic slice_t to_slice(input logic [FIELD_W-1:0] v);
    slice_t r;
    r = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (i < SLICE_BITS) r[i] = v[i];
    end
    return r;
  endfunction

  // slice -> field width (truncate or zero-extend)
  function automatic logic [FIELD_W-1:0] to_field(input slice_t v);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLICE_BITS; i++) begin
      if (i < FIELD_W) r[i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== src/hbne_front.sv =====
// ---------------------------------------------------------------------------
// hbne_front
// Input stage: registers the slice, masks it and saturates the radius.
// ---------------------------------------------------------------------------
module hbne_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hbne_pkg::FIELD_W-1:0]  slice_value,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    radius,
  input  logic                          q_full,
  output logic                          push,
  output hbne_pkg::job_t                push_job
);
  import hbne_pkg::*;

  logic       fv;
  job_t       fjob;
  logic [1:0] rad_sat;

  assign rad_sat  = (radius > RADIUS_MAX) ? RADIUS_MAX : radius;
  assign push     = fv && !q_full;
  assign in_ready = !fv || !q_full;
  assign push_job = fjob;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fjob.val <= to_slice(slice_value);
      fjob.rad <= rad_sat;
    end
  end

endmodule

// ===== src/hbne_queue.sv =====
// ---------------------------------------------------------------------------
// hbne_queue
// Short job FIFO between front and back.
// ---------------------------------------------------------------------------
module hbne_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hbne_pkg::job_t  push_job,
  input  logic            pop,
  output hbne_pkg::job_t  pop_job,
  output hbne_pkg::qstat_t stat
);
  import hbne_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  assign stat.full     = (count == CNT_FULL);
  assign stat.nonempty = (count != '0);
  assign stat.count    = count;
  assign pop_job       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/hbne_back.sv =====
// ---------------------------------------------------------------------------
// hbne_back
// Enumeration sequencer: walks distance 0, 1, 2 position sets and drives
// one neighbour per cycle into the output register while the output is not stalled.
// ---------------------------------------------------------------------------
module hbne_back (
  input  logic                          clk,
  input  logic                          rst,
  input  hbne_pkg::qstat_t              qstat,
  input  hbne_pkg::job_t                pop_job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbne_pkg::FIELD_W-1:0]  neighbour_value,
  output logic [1:0]                    distance,
  output logic                          last
);
  import hbne_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SLICE_BITS - 1);
  localparam logic [POS_W-1:0] POS_PEN  = POS_W'(SLICE_BITS - 2);
  localparam slice_t           ONE      = slice_t'(1);

  logic             cur_valid;
  slice_t           cur_val;
  logic [1:0]       cur_rad;
  logic [1:0]       cur_dist;
  logic [POS_W-1:0] pa;
  logic [POS_W-1:0] pb;

  logic   emit;
  logic   last_now;
  slice_t flip;

  assign emit = cur_valid && (!out_valid || out_ready);
  assign pop  = !cur_valid && qstat.nonempty;

  // position index 0 is the MSB of the slice
  always_comb begin
    flip = '0;
    if (cur_dist != DIST0) flip = flip | (ONE << (POS_LAST - pa));
    if (cur_dist == DIST2) flip = flip | (ONE << (POS_LAST - pb));
  end

  always_comb begin
    case (cur_dist)
      DIST0:   last_now = (cur_rad == DIST0);
      DIST1:   last_now = (cur_rad == DIST1) && (pa == POS_LAST);
      DIST2:   last_now = (pa == POS_PEN) && (pb == POS_LAST);
      default: last_now = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (emit && last_now) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_val  <= pop_job.val;
      cur_rad  <= pop_job.rad;
      cur_dist <= DIST0;
      pa       <= '0;
      pb       <= POS_W'(1);
    end else if (emit && !last_now) begin
      case (cur_dist)
        DIST0: begin
          cur_dist <= DIST1;
          pa       <= '0;
        end
        DIST1: begin
          if (pa == POS_LAST) begin
            cur_dist <= DIST2;
            pa       <= '0;
            pb       <= POS_W'(1);
          end else begin
            pa <= pa + 1'b1;
          end
        end
        default: begin
          if (pb == POS_LAST) begin
            pa <= pa + 1'b1;
            pb <= POS_W'(pa + 2'd2);
          end else begin
            pb <= pb + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      neighbour_value <= to_field(cur_val ^ flip);
      distance        <= cur_dist;
      last            <= last_now;
    end
  end

endmodule

// ===== src/hamming_ball_neighbour_enumerator_core.sv =====
// ---------------------------------------------------------------------------
// hamming_ball_neighbour_enumerator_core
// Path from input transaction to first result: front register, queue, back
//   load, output register; then one neighbour per cycle while the output
//   is not stalled: 1 + 8 + 28 = 37 results at radius 2, 9 at radius 1,
//   1 at radius 0. The back sequencer loads the next job from the queue
//   only after emitting the last neighbour of the current one.
// Reset (rst, synchronous): empties front, queue and output; radius = 1.
// ---------------------------------------------------------------------------
module hamming_ball_neighbour_enumerator_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: radius register
  input  logic                          cfg_wen,
  input  logic [1:0]                    cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hbne_pkg::FIELD_W-1:0]  slice_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbne_pkg::FIELD_W-1:0]  neighbour_value,
  output logic [1:0]                    distance,
  output logic                          last
);
  import hbne_pkg::*;

  // Radius register. Saturation to MAX_RADIUS happens in the front, so the
  // raw 2-bit code is kept here.
  logic [1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
    end else if (cfg_wen) begin
      radius <= cfg_wdata;
    end
  end

  // Front -> queue -> back. Each transaction is captured as a job (masked
  // slice + saturated radius); the back stalls only on the output side.
  logic   push;
  job_t   push_job;
  logic   pop;
  job_t   pop_job;
  qstat_t qstat;

  hbne_front u_front (
    .clk         (clk),
    .rst         (rst),
    .slice_value (slice_value),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .radius      (radius),
    .q_full      (qstat.full),
    .push        (push),
    .push_job    (push_job)
  );

  hbne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (qstat)
  );

  hbne_back u_back (
    .clk             (clk),
    .rst             (rst),
    .qstat           (qstat),
    .pop_job         (pop_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .neighbour_value (neighbour_value),
    .distance        (distance),
    .last            (last)
  );

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------

  // a non-final neighbour taken means the sequencer has the next one ready
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("gap inside one item's neighbour burst");

  // queue occupancy bounded
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("job queue overflow");

  // a sequencer load only pops a non-empty queue, never while a push meets a full queue
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty && !(push && qstat.full))
    else $error("queue pop/push inconsistent");

endmodule
